>>> hdl/oale_pkg.sv
// Shared constants, codes and types of the ordered array list engine.
package oale_pkg;

	localparam int CAPACITY    = 128;
	localparam int VALUE_WIDTH = 32;
	localparam int AW          = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_LOCATE = 2'd2,
		KIND_GET    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef struct packed {
		logic                   rd_en;
		logic [AW-1:0]          rd_addr;
		logic                   wr_en;
		logic [AW-1:0]          wr_addr;
		logic [VALUE_WIDTH-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  found;
		logic [31:0] rdval;
		logic [7:0]  count;
	} result_t;

endpackage

>>> hdl/ordered_array_list_engine_top.sv
// Top level of the ordered array list engine: sequencer, entry storage, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  request | in        | in_valid / in_ready  | kind, position, value
//  result  | out       | out_valid / out_ready| status, found_position, read_value, count
//
// One request at a time over the single memory port; rejected requests skip to the result.
// Insert moves the entries from position on up by one, then writes; an append only writes.
// Delete moves later entries down (last entry: count only); locate scans from the first entry.
// Reset clears count and out_valid, not the entries, which are read only after being written.
// The result register lets the next request transfer while a result waits on out_ready.
module ordered_array_list_engine_top
	import oale_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  position,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  found_position,
	output logic [31:0] read_value,
	output logic [7:0]  count
);

	mem_req_t               req;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   res_valid;
	logic                   res_take;
	result_t                res;
	result_t                out_q;
	logic                   out_valid_q;

	oale_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.position  (position),
		.value     (value),
		.req       (req),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	oale_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign found_position = out_q.found;
	assign read_value     = out_q.rdval;
	assign count          = out_q.count;

endmodule

>>> hdl/oale_store.sv
// Entry storage: one write port and one registered read port.
module oale_store
	import oale_pkg::*;
(
	input  logic                   clk,
	input  mem_req_t               req,
	output logic [VALUE_WIDTH-1:0] rd_data
);

	logic [VALUE_WIDTH-1:0] mem [CAPACITY];
	logic [VALUE_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/oale_seq.sv
// Request sequencer: range checks, shift walks, search and fetch over one memory port.
module oale_seq
	import oale_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             kind,
	input  logic [7:0]             position,
	input  logic [31:0]            value,
	output mem_req_t               req,
	input  logic [VALUE_WIDTH-1:0] rd_data,
	output logic                   res_valid,
	input  logic                   res_take,
	output result_t                res
);

	localparam int PW = ((CNT_W > 8) ? CNT_W : 8) + 1;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_UP   = 10'b0000000010,
		S_UPW  = 10'b0000000100,
		S_INSW = 10'b0000001000,
		S_DN   = 10'b0000010000,
		S_DNW  = 10'b0000100000,
		S_SRCH = 10'b0001000000,
		S_GET  = 10'b0010000000,
		S_GETD = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [AW-1:0]          ptr_q;
	logic [AW-1:0]          tgt_q;
	logic [AW-1:0]          wa_q;
	logic                   pend_q;
	status_t                st_q;
	logic [7:0]             found_q;
	logic [31:0]            rdv_q;

	logic [PW-1:0]          pos_x;
	logic [PW-1:0]          cnt_x;
	logic                   ins_ok;
	logic                   rng_ok;
	logic                   full;
	logic [AW-1:0]          pos_m1;
	logic [AW-1:0]          cnt_m1;
	logic [63:0]            vsx;
	logic [VALUE_WIDTH-1:0] val_in;
	logic [AW+8:0]          fx;
	logic [VALUE_WIDTH+31:0] rdx;
	logic [CNT_W+7:0]       cx;
	logic                   accept;

	assign pos_x  = PW'(position);
	assign cnt_x  = PW'(count_q);
	assign ins_ok = (position != 8'd0) && (pos_x <= cnt_x + PW'(1));
	assign rng_ok = (position != 8'd0) && (pos_x <= cnt_x);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign pos_m1 = AW'(pos_x - PW'(1));
	assign cnt_m1 = AW'(cnt_x - PW'(1));
	assign vsx    = {{32{value[31]}}, value};
	assign val_in = vsx[VALUE_WIDTH-1:0];
	assign fx     = {9'b0, wa_q} + {{(AW+8){1'b0}}, 1'b1};
	assign rdx    = {32'b0, rd_data};
	assign cx     = {8'b0, count_q};

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_DONE);

	assign res.status = st_q;
	assign res.found  = found_q;
	assign res.rdval  = rdv_q;
	assign res.count  = cx[7:0];

	always_comb begin
		req = '0;
		case (state_q)
			S_UP, S_DN: begin
				req.rd_en   = 1'b1;
				req.rd_addr = ptr_q;
				req.wr_en   = pend_q;
				req.wr_addr = wa_q;
				req.wr_data = rd_data;
			end
			S_UPW, S_DNW: begin
				req.wr_en   = 1'b1;
				req.wr_addr = wa_q;
				req.wr_data = rd_data;
			end
			S_INSW: begin
				req.wr_en   = 1'b1;
				req.wr_addr = tgt_q;
				req.wr_data = val_q;
			end
			S_SRCH, S_GET: begin
				req.rd_en   = 1'b1;
				req.rd_addr = ptr_q;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_q <= 1'b0;
						case (kind_t'(kind))
							KIND_INSERT: begin
								if (!ins_ok || full) begin
									state_q <= S_DONE;
								end else if (pos_x == cnt_x + PW'(1)) begin
									state_q <= S_INSW;
								end else begin
									state_q <= S_UP;
								end
							end
							KIND_DELETE: begin
								if (!rng_ok) begin
									state_q <= S_DONE;
								end else if (pos_x == cnt_x) begin
									count_q <= count_q - CNT_W'(1);
									state_q <= S_DONE;
								end else begin
									state_q <= S_DN;
								end
							end
							KIND_LOCATE: begin
								state_q <= (count_q == '0) ? S_DONE : S_SRCH;
							end
							default: begin
								state_q <= rng_ok ? S_GET : S_DONE;
							end
						endcase
					end
				end
				S_UP: begin
					pend_q <= 1'b1;
					if (ptr_q == tgt_q) begin
						state_q <= S_UPW;
					end
				end
				S_UPW: begin
					state_q <= S_INSW;
				end
				S_INSW: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DN: begin
					pend_q <= 1'b1;
					if (ptr_q == tgt_q) begin
						state_q <= S_DNW;
					end
				end
				S_DNW: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= S_DONE;
				end
				S_SRCH: begin
					pend_q <= 1'b1;
					if (pend_q && ((rd_data == val_q) || (wa_q == tgt_q))) begin
						state_q <= S_DONE;
					end
				end
				S_GET: begin
					state_q <= S_GETD;
				end
				S_GETD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q   <= val_in;
					st_q    <= ST_OK;
					found_q <= 8'd0;
					rdv_q   <= 32'd0;
					case (kind_t'(kind))
						KIND_INSERT: begin
							tgt_q <= pos_m1;
							ptr_q <= cnt_m1;
							if (!ins_ok) begin
								st_q <= ST_RANGE;
							end else if (full) begin
								st_q <= ST_FULL;
							end
						end
						KIND_DELETE: begin
							tgt_q <= cnt_m1;
							ptr_q <= AW'(pos_x);
							if (!rng_ok) begin
								st_q <= ST_RANGE;
							end
						end
						KIND_LOCATE: begin
							tgt_q <= cnt_m1;
							ptr_q <= '0;
							if (count_q == '0) begin
								st_q <= ST_MISS;
							end
						end
						default: begin
							ptr_q <= pos_m1;
							if (!rng_ok) begin
								st_q <= ST_RANGE;
							end
						end
					endcase
				end
			end
			S_UP: begin
				wa_q  <= ptr_q + AW'(1);
				ptr_q <= ptr_q - AW'(1);
			end
			S_DN: begin
				wa_q  <= ptr_q - AW'(1);
				ptr_q <= ptr_q + AW'(1);
			end
			S_SRCH: begin
				wa_q  <= ptr_q;
				ptr_q <= ptr_q + AW'(1);
				if (pend_q) begin
					if (rd_data == val_q) begin
						found_q <= fx[7:0];
					end else if (wa_q == tgt_q) begin
						st_q <= ST_MISS;
					end
				end
			end
			S_GETD: begin
				rdv_q <= rdx[31:0];
			end
			default: begin
			end
		endcase
	end

endmodule
